// ===== hw/rtl/point_depth_visibility_test_defines.svh =====
// Assertion helpers shared by the RTL of the depth visibility block.
`ifndef POINT_DEPTH_VISIBILITY_TEST_DEFINES_SVH
`define POINT_DEPTH_VISIBILITY_TEST_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define PDVT_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pdvt assertion failed");

// Next-cycle implication, clocked on clk, off while in reset.
`define PDVT_ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pdvt assertion failed");

`endif

// ===== hw/rtl/pdvt_pkg.sv =====
package pdvt_pkg;

    // Depth store geometry
    localparam int MAP_WIDTH  = 256;
    localparam int MAP_HEIGHT = 256;
    localparam int MAP_DEPTH  = MAP_WIDTH * MAP_HEIGHT;
    localparam int ADDR_W     = $clog2(MAP_DEPTH);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_ZERO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_ONE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_TWO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTRINSICS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ERROR    = 3'd7;

    // Register reset values
    localparam logic [47:0] RST_ROT_ROW_ZERO = 48'd16384;
    localparam logic [47:0] RST_ROT_ROW_ONE  = 48'd1073741824;
    localparam logic [47:0] RST_ROT_ROW_TWO  = 48'd70368744177664;
    localparam logic [17:0] RST_IMAGE_SIZE   = 18'd131328;
    localparam logic [15:0] RST_MAX_ERROR    = 16'd655;

    // Result status codes
    localparam logic [2:0] STAT_MATCH    = 3'd0;
    localparam logic [2:0] STAT_BEHIND   = 3'd1;
    localparam logic [2:0] STAT_OUTSIDE  = 3'd2;
    localparam logic [2:0] STAT_INVALID  = 3'd3;
    localparam logic [2:0] STAT_MISMATCH = 3'd4;
    localparam logic [2:0] STAT_BYPASS   = 3'd5;

    // Input item
    typedef struct packed {
        logic               func;
        logic signed [19:0] point_x;
        logic signed [19:0] point_y;
        logic signed [19:0] point_z;
        logic [7:0]         map_row;
        logic [7:0]         map_col;
        logic [19:0]        map_depth;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic        visible;
        logic [2:0]  status;
        logic [7:0]  pixel_col;
        logic [7:0]  pixel_row;
        logic [19:0] cam_depth;
    } out_item_t;

endpackage

// ===== hw/rtl/point_depth_visibility_test.sv =====
// Throughput: one item per cycle; the whole pipeline holds only while a result waits.
// Pixel rounding runs through a 9-stage restoring divider; the depth store read is
// registered in the stage after the divider ends. After rst_n the 65536-entry depth
// store is cleared one entry per cycle (in_ready low); config writes are taken.
// Control and configuration registers reset asynchronously; payload does not.
`include "point_depth_visibility_test_defines.svh"

module point_depth_visibility_test (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pdvt_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pdvt_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [pdvt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pdvt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int CAM_W = 39;   // camera coordinates, 14 fractional bits
    localparam int UN_W  = 58;   // projected numerators
    localparam int NUM_W = 54;   // divider operands
    localparam int QW    = 9;    // pixel quotient width
    localparam int DIV0  = 4;
    localparam int DIVN  = DIV0 + QW;
    localparam int ST_RD = DIVN + 1;
    localparam int ST_DC = ST_RD + 1;

    typedef struct packed {
        logic                           func;
        logic                           wok;
        logic [pdvt_pkg::ADDR_W-1:0]    waddr;
        logic [19:0]                    wdepth;
    } tag_t;

    typedef struct packed {
        logic signed [CAM_W-1:0] z;
        logic [19:0]             zq;
        logic                    bypass;
        logic                    behind;
        logic                    outside;
    } car_t;

    // Configuration registers
    logic        check_en_reg;
    logic [47:0] rot_reg [3];
    logic [59:0] trans_reg;
    logic [47:0] intr_reg;
    logic [17:0] size_reg;
    logic [15:0] maxerr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_en_reg <= 1'b0;
            rot_reg[0]   <= pdvt_pkg::RST_ROT_ROW_ZERO;
            rot_reg[1]   <= pdvt_pkg::RST_ROT_ROW_ONE;
            rot_reg[2]   <= pdvt_pkg::RST_ROT_ROW_TWO;
            trans_reg    <= '0;
            intr_reg     <= '0;
            size_reg     <= pdvt_pkg::RST_IMAGE_SIZE;
            maxerr_reg   <= pdvt_pkg::RST_MAX_ERROR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pdvt_pkg::REG_CHECK_ENABLE: check_en_reg <= cfg_wdata[0];
                pdvt_pkg::REG_ROT_ROW_ZERO: rot_reg[0]   <= cfg_wdata[47:0];
                pdvt_pkg::REG_ROT_ROW_ONE:  rot_reg[1]   <= cfg_wdata[47:0];
                pdvt_pkg::REG_ROT_ROW_TWO:  rot_reg[2]   <= cfg_wdata[47:0];
                pdvt_pkg::REG_TRANSLATION:  trans_reg    <= cfg_wdata[59:0];
                pdvt_pkg::REG_INTRINSICS:   intr_reg     <= cfg_wdata[47:0];
                pdvt_pkg::REG_IMAGE_SIZE:   size_reg     <= cfg_wdata[17:0];
                pdvt_pkg::REG_MAX_ERROR:    maxerr_reg   <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Clearing pass over the depth store
    logic                        clearing_reg;
    logic [pdvt_pkg::ADDR_W-1:0] clr_addr_reg;
    logic                        clr_last;

    assign clr_last = (clr_addr_reg == pdvt_pkg::ADDR_W'(pdvt_pkg::MAP_DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_last)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Pipeline advance: everything moves unless a result waits
    logic                pipe_en;
    logic                out_valid_reg;
    pdvt_pkg::out_item_t out_data_reg;

    assign pipe_en  = !out_valid_reg || out_ready;
    assign in_ready = pipe_en && !clearing_reg;

    logic v_reg   [0:ST_DC];
    tag_t tag_reg [0:ST_DC];
    car_t car_reg [3:ST_DC];

    // Write fields of the incoming item
    tag_t in_tag;
    always_comb
    begin
        in_tag.func   = in_data.func;
        in_tag.wok    = (32'(in_data.map_row) < pdvt_pkg::MAP_HEIGHT) &&
                        (32'(in_data.map_col) < pdvt_pkg::MAP_WIDTH);
        in_tag.waddr  = pdvt_pkg::ADDR_W'(32'(in_data.map_row) * pdvt_pkg::MAP_WIDTH +
                                          32'(in_data.map_col));
        in_tag.wdepth = in_data.map_depth;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ST_DC; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (pipe_en)
        begin
            v_reg[0] <= in_valid && in_ready;
            for (int k = 1; k <= ST_DC; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            tag_reg[0] <= in_tag;
            for (int k = 1; k <= ST_DC; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // Stage 0: input point
    logic signed [19:0] pt_reg [3];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            pt_reg[0] <= in_data.point_x;
            pt_reg[1] <= in_data.point_y;
            pt_reg[2] <= in_data.point_z;
        end
    end

    // Stage 1: rotation products
    logic signed [35:0] prod_reg [3][3];
    logic signed [15:0] rot_e [3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                rot_e[i][j] = rot_reg[i][16*j +: 16];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= rot_e[i][j] * pt_reg[j];
                end
            end
        end
    end

    // Stage 2: camera coordinates
    logic signed [CAM_W-1:0] cam_reg [3];
    logic signed [19:0]      trans_e [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            trans_e[i] = trans_reg[20*i +: 20];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cam_reg[i] <= (CAM_W'(trans_e[i]) <<< 14) + CAM_W'(prod_reg[i][0]) +
                              CAM_W'(prod_reg[i][1]) + CAM_W'(prod_reg[i][2]);
            end
        end
    end

    // Stage 3: projection products and depth rounding
    logic signed [UN_W-1:0]  fx3_reg, cxz3_reg, fy3_reg, cyz3_reg, wz3_reg, hz3_reg;
    logic signed [16:0]      f_s, cx_s, cy_s;
    logic signed [9:0]       w_s, h_s;
    logic signed [CAM_W-1:0] z_rnd;
    car_t                    car3;

    always_comb
    begin
        f_s  = $signed({1'b0, intr_reg[15:0]});
        cx_s = $signed({1'b0, intr_reg[31:16]});
        cy_s = $signed({1'b0, intr_reg[47:32]});
        w_s  = $signed({1'b0, size_reg[8:0]});
        h_s  = $signed({1'b0, size_reg[17:9]});
        z_rnd        = cam_reg[2] + CAM_W'(8192);
        car3.z       = cam_reg[2];
        car3.behind  = !(cam_reg[2] > 0);
        car3.bypass  = !check_en_reg;
        car3.outside = 1'b0;
        if (car3.behind)
            car3.zq = '0;
        else if (|z_rnd[CAM_W-1:34])
            car3.zq = '1;
        else
            car3.zq = z_rnd[33:14];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            fx3_reg    <= f_s * cam_reg[0];
            cxz3_reg   <= cx_s * cam_reg[2];
            fy3_reg    <= f_s * cam_reg[1];
            cyz3_reg   <= cy_s * cam_reg[2];
            wz3_reg    <= (w_s * cam_reg[2]) <<< 4;
            hz3_reg    <= (h_s * cam_reg[2]) <<< 4;
            car_reg[3] <= car3;
        end
    end

    // Stage 4: image bounds, divider operands
    logic signed [UN_W-1:0] un4, vn4, z4w;
    logic [NUM_W-1:0]       div_rem_c_reg [DIV0:DIVN-1];
    logic [NUM_W-1:0]       div_rem_r_reg [DIV0:DIVN-1];
    logic [NUM_W-1:0]       div_dd_reg    [DIV0:DIVN-1];
    logic [QW-1:0]          div_q_c_reg   [DIV0:DIVN];
    logic [QW-1:0]          div_q_r_reg   [DIV0:DIVN];
    car_t                   car4;

    always_comb
    begin
        un4  = fx3_reg + cxz3_reg;
        vn4  = fy3_reg + cyz3_reg;
        z4w  = UN_W'(car_reg[3].z);
        car4 = car_reg[3];
        car4.outside = (un4 < 0) || (vn4 < 0) || (un4 >= wz3_reg) || (vn4 >= hz3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            div_rem_c_reg[DIV0] <= NUM_W'((un4 <<< 1) + (z4w <<< 4));
            div_rem_r_reg[DIV0] <= NUM_W'((vn4 <<< 1) + (z4w <<< 4));
            div_dd_reg[DIV0]    <= NUM_W'(z4w <<< 5);
            div_q_c_reg[DIV0]   <= '0;
            div_q_r_reg[DIV0]   <= '0;
            car_reg[DIV0]       <= car4;
        end
    end

    // Divider: one quotient bit per stage, most significant first
    logic [NUM_W-1:0] trial [QW];
    logic             ge_c  [QW];
    logic             ge_r  [QW];

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            trial[k] = div_dd_reg[DIV0+k] << (QW - 1 - k);
            ge_c[k]  = div_rem_c_reg[DIV0+k] >= trial[k];
            ge_r[k]  = div_rem_r_reg[DIV0+k] >= trial[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            // the last stage keeps only the quotient
            for (int k = 0; k < QW - 1; k++)
            begin
                div_dd_reg[DIV0+k+1] <= div_dd_reg[DIV0+k];
                div_rem_c_reg[DIV0+k+1] <= ge_c[k] ? div_rem_c_reg[DIV0+k] - trial[k]
                                                   : div_rem_c_reg[DIV0+k];
                div_rem_r_reg[DIV0+k+1] <= ge_r[k] ? div_rem_r_reg[DIV0+k] - trial[k]
                                                   : div_rem_r_reg[DIV0+k];
            end
            for (int k = 0; k < QW; k++)
            begin
                car_reg[DIV0+k+1]    <= car_reg[DIV0+k];
                div_q_c_reg[DIV0+k+1] <= div_q_c_reg[DIV0+k] |
                                         (QW'(ge_c[k]) << (QW - 1 - k));
                div_q_r_reg[DIV0+k+1] <= div_q_r_reg[DIV0+k] |
                                         (QW'(ge_r[k]) << (QW - 1 - k));
            end
        end
    end

    // Depth store: writes and reads both happen at the end of the divider,
    // so a write always lands before any later item reads
    logic [19:0]                 depth_mem [0:pdvt_pkg::MAP_DEPTH-1];
    logic [19:0]                 rd_data_reg;
    logic [pdvt_pkg::ADDR_W-1:0] raddr;
    logic                        inmap13;
    logic                        mem_we;
    logic [pdvt_pkg::ADDR_W-1:0] mem_waddr;
    logic [19:0]                 mem_wdata;

    always_comb
    begin
        inmap13 = (32'(div_q_c_reg[DIVN]) < pdvt_pkg::MAP_WIDTH) &&
                  (32'(div_q_r_reg[DIVN]) < pdvt_pkg::MAP_HEIGHT);
        raddr   = pdvt_pkg::ADDR_W'(32'(div_q_r_reg[DIVN]) * pdvt_pkg::MAP_WIDTH +
                                    32'(div_q_c_reg[DIVN]));
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = pipe_en && v_reg[DIVN] && !tag_reg[DIVN].func && tag_reg[DIVN].wok;
            mem_waddr = tag_reg[DIVN].waddr;
            mem_wdata = tag_reg[DIVN].wdepth;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            depth_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            rd_data_reg <= depth_mem[raddr];
        end
    end

    // Stage 14: pixel alongside the read
    logic [7:0] col14_reg, row14_reg;
    logic       inmap14_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            col14_reg      <= div_q_c_reg[DIVN][7:0];
            row14_reg      <= div_q_r_reg[DIVN][7:0];
            inmap14_reg    <= inmap13;
            car_reg[ST_RD] <= car_reg[DIVN];
        end
    end

    // Stage 15: depth difference and error bound
    logic [CAM_W-1:0] z_u, d_sh, diff;
    logic [7:0]       col15_reg, row15_reg;
    logic             inmap15_reg, dzero15_reg;
    logic [40:0]      lhs15_reg;
    logic [35:0]      rhs15_reg;

    always_comb
    begin
        z_u  = car_reg[ST_RD].z;
        d_sh = CAM_W'({rd_data_reg, 14'b0});
        diff = (z_u > d_sh) ? z_u - d_sh : d_sh - z_u;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            col15_reg      <= col14_reg;
            row15_reg      <= row14_reg;
            inmap15_reg    <= inmap14_reg;
            dzero15_reg    <= (rd_data_reg == '0);
            lhs15_reg      <= {diff, 2'b00};
            rhs15_reg      <= maxerr_reg * rd_data_reg;
            car_reg[ST_DC] <= car_reg[ST_RD];
        end
    end

    // Result selection
    pdvt_pkg::out_item_t res;

    always_comb
    begin
        res.visible   = 1'b0;
        res.status    = pdvt_pkg::STAT_MATCH;
        res.pixel_col = '0;
        res.pixel_row = '0;
        res.cam_depth = car_reg[ST_DC].zq;
        if (car_reg[ST_DC].bypass)
        begin
            res.visible = 1'b1;
            res.status  = pdvt_pkg::STAT_BYPASS;
        end
        else if (car_reg[ST_DC].behind)
        begin
            res.status = pdvt_pkg::STAT_BEHIND;
        end
        else if (car_reg[ST_DC].outside || !inmap15_reg)
        begin
            res.status = pdvt_pkg::STAT_OUTSIDE;
        end
        else
        begin
            res.pixel_col = col15_reg;
            res.pixel_row = row15_reg;
            if (dzero15_reg)
                res.status = pdvt_pkg::STAT_INVALID;
            else if (lhs15_reg <= 41'(rhs15_reg))
                res.visible = 1'b1;
            else
                res.status = pdvt_pkg::STAT_MISMATCH;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pipe_en)
            out_valid_reg <= v_reg[ST_DC] && tag_reg[ST_DC].func;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Assertions
    logic out_stat_ok;

    assign out_stat_ok = (out_data_reg.status == pdvt_pkg::STAT_MATCH) ||
                         (out_data_reg.status == pdvt_pkg::STAT_BYPASS);

    `PDVT_ASSERT_IMP(a_clear_blocks_input, clearing_reg, !in_ready)
    `PDVT_ASSERT_IMP(a_wait_stalls_pipe, out_valid_reg && !out_ready, !pipe_en && !in_ready)
    `PDVT_ASSERT_NXT(a_clear_ends, clearing_reg && clr_last, !clearing_reg)
    `PDVT_ASSERT_IMP(a_visible_status, out_valid_reg && out_data_reg.visible, out_stat_ok)

endmodule

// ===== test/pdvt_checker.sv =====
module pdvt_checker
    import pdvt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending
);

    // Shadow registers and depth store
    logic        chk_en;
    logic [47:0] rot_row [3];
    logic [59:0] trans;
    logic [47:0] intr;
    logic [17:0] img_size;
    logic [15:0] max_err;
    logic [19:0] depth_mem [MAP_DEPTH];

    out_item_t result_q [$];

    assign pending = result_q.size();

    // Expected result of one test item
    function automatic out_item_t project_point(in_item_t it);
        out_item_t r;
        longint p [3];
        longint cam [3];
        longint acc, z, q, f, cx, cy, w, h, un, vn, col, row;
        longint unsigned d, zz, diff, lhs, rhs;
        p[0] = it.point_x;
        p[1] = it.point_y;
        p[2] = it.point_z;
        for (int i = 0; i < 3; i++)
        begin
            acc = longint'($signed(trans[20*i +: 20])) * 16384;
            for (int j = 0; j < 3; j++)
                acc += longint'($signed(rot_row[i][16*j +: 16])) * p[j];
            cam[i] = acc;
        end
        z = cam[2];
        r = '0;
        if (z > 0)
        begin
            q = (z + 8192) / 16384;
            r.cam_depth = (q > 64'sd1048575) ? 20'hFFFFF : q[19:0];
        end
        if (!chk_en)
        begin
            r.visible = 1'b1;
            r.status  = STAT_BYPASS;
            return r;
        end
        if (z <= 0)
        begin
            r.status = STAT_BEHIND;
            return r;
        end
        f  = intr[15:0];
        cx = intr[31:16];
        cy = intr[47:32];
        w  = img_size[8:0];
        h  = img_size[17:9];
        un = f * cam[0] + cx * z;
        vn = f * cam[1] + cy * z;
        if (un < 0 || vn < 0 || un >= w * 16 * z || vn >= h * 16 * z)
        begin
            r.status = STAT_OUTSIDE;
            return r;
        end
        col = (2 * un + 16 * z) / (32 * z);
        row = (2 * vn + 16 * z) / (32 * z);
        if (row >= MAP_HEIGHT || col >= MAP_WIDTH)
        begin
            r.status = STAT_OUTSIDE;
            return r;
        end
        r.pixel_col = col[7:0];
        r.pixel_row = row[7:0];
        d = depth_mem[row * MAP_WIDTH + col];
        if (d == 0)
        begin
            r.status = STAT_INVALID;
            return r;
        end
        zz   = z;
        d    = d << 14;
        diff = (zz > d) ? zz - d : d - zz;
        lhs  = diff << 16;
        rhs  = longint'(max_err) * d;
        if (lhs <= rhs)
        begin
            r.visible = 1'b1;
            r.status  = STAT_MATCH;
        end
        else
            r.status = STAT_MISMATCH;
        return r;
    endfunction

    // Track configuration, predict on input transfers, compare on output
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            chk_en     <= 1'b0;
            rot_row[0] <= RST_ROT_ROW_ZERO;
            rot_row[1] <= RST_ROT_ROW_ONE;
            rot_row[2] <= RST_ROT_ROW_TWO;
            trans      <= '0;
            intr       <= '0;
            img_size   <= RST_IMAGE_SIZE;
            max_err    <= RST_MAX_ERROR;
            for (int k = 0; k < MAP_DEPTH; k++)
                depth_mem[k] = '0;
            result_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CHECK_ENABLE: chk_en     <= cfg_wdata[0];
                    REG_ROT_ROW_ZERO: rot_row[0] <= cfg_wdata[47:0];
                    REG_ROT_ROW_ONE:  rot_row[1] <= cfg_wdata[47:0];
                    REG_ROT_ROW_TWO:  rot_row[2] <= cfg_wdata[47:0];
                    REG_TRANSLATION:  trans      <= cfg_wdata[59:0];
                    REG_INTRINSICS:   intr       <= cfg_wdata[47:0];
                    REG_IMAGE_SIZE:   img_size   <= cfg_wdata[17:0];
                    REG_MAX_ERROR:    max_err    <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (in_data.func)
                    result_q = {result_q, project_point(in_data)};
                else
                    depth_mem[{in_data.map_row, in_data.map_col}] = in_data.map_depth;
            end
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("unexpected result transfer %p", out_data);
                    fail_count++;
                end
                else
                begin
                    e = result_q.pop_front();
                    if (out_data.visible !== e.visible)
                    begin
                        $error("visible exp %0h got %0h", e.visible, out_data.visible);
                        fail_count++;
                    end
                    if (out_data.status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.pixel_col !== e.pixel_col)
                    begin
                        $error("pixel_col exp %0d got %0d", e.pixel_col,
                               out_data.pixel_col);
                        fail_count++;
                    end
                    if (out_data.pixel_row !== e.pixel_row)
                    begin
                        $error("pixel_row exp %0d got %0d", e.pixel_row,
                               out_data.pixel_row);
                        fail_count++;
                    end
                    if (out_data.cam_depth !== e.cam_depth)
                    begin
                        $error("cam_depth exp %0h got %0h", e.cam_depth,
                               out_data.cam_depth);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== test/tb_point_depth_visibility_test.sv =====
module tb_point_depth_visibility_test;
    import pdvt_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int                    fail_count;
    int                    pending;
    bit                    hold_off = 1'b0;

    // Tracks of the map written with depths; test points aim at them
    logic [7:0]  wr_row [$];
    logic [7:0]  wr_col [$];
    logic [19:0] wr_dep [$];

    always #10 clk = ~clk;

    point_depth_visibility_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    pdvt_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: random stall pattern, with quiet stretches and a long hold-off
    initial
    begin
        int mode;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) == 0)
                mode = $urandom_range(0, 2);
            if (hold_off)
                out_ready <= 1'b0;
            else if (mode == 0)
                out_ready <= 1'b1;
            else if (mode == 1)
                out_ready <= ($urandom_range(0, 3) != 0);
            else
                out_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Present one item and hold it until the transfer
    task automatic send_item(in_item_t it);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic pause_sender();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6))
            @(posedge clk);
    endtask

    task automatic drain_results();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (24)
            @(posedge clk);
    endtask

    function automatic in_item_t depth_write(logic [7:0] r, logic [7:0] c, logic [19:0] d);
        in_item_t it;
        it = '0;
        it.point_x   = 20'($urandom);
        it.point_y   = 20'($urandom);
        it.point_z   = 20'($urandom);
        it.map_row   = r;
        it.map_col   = c;
        it.map_depth = d;
        return it;
    endfunction

    function automatic in_item_t test_point(logic signed [19:0] x, logic signed [19:0] y,
                                            logic signed [19:0] z);
        in_item_t it;
        it = '0;
        it.func      = 1'b1;
        it.point_x   = x;
        it.point_y   = y;
        it.point_z   = z;
        it.map_row   = 8'($urandom);
        it.map_col   = 8'($urandom);
        it.map_depth = 20'($urandom);
        return it;
    endfunction

    // Random item under the identity camera with focal 1 px, center 128:
    // pixel is (x/z + 128); mostly aimed at written entries
    function automatic in_item_t random_item();
        in_item_t it;
        int k, zi, sel;
        logic [19:0] d;
        sel = $urandom_range(0, 99);
        if (sel < 35)
        begin
            d = ($urandom_range(0, 9) == 0) ? 20'd0 :
                ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(1, 4096));
            it = depth_write(8'($urandom), 8'($urandom), d);
            wr_row = {wr_row, it.map_row};
            wr_col = {wr_col, it.map_col};
            wr_dep = {wr_dep, it.map_depth};
            if (wr_row.size() > 64)
            begin
                void'(wr_row.pop_front());
                void'(wr_col.pop_front());
                void'(wr_dep.pop_front());
            end
        end
        else if (sel < 80 && wr_row.size() != 0)
        begin
            // Point that lands on a written pixel with a depth near the stored one
            k  = $urandom_range(0, wr_row.size() - 1);
            zi = int'(wr_dep[k]) + $urandom_range(0, 8) - 4;
            if (zi < 1)
                zi = 1;
            if (zi > 4096)
                zi = 4096;
            it = test_point(20'((int'(wr_col[k]) - 128) * zi),
                            20'((int'(wr_row[k]) - 128) * zi), 20'(zi));
        end
        else
            it = test_point(20'($urandom), 20'($urandom), 20'($urandom));
        return it;
    endfunction

    task automatic camera_setup(bit en, logic [15:0] err, logic [17:0] isz);
        cfg_write(REG_CHECK_ENABLE, 60'(en));
        cfg_write(REG_ROT_ROW_ZERO, 60'd16384);
        cfg_write(REG_ROT_ROW_ONE,  60'd1073741824);
        cfg_write(REG_ROT_ROW_TWO,  60'd70368744177664);
        cfg_write(REG_TRANSLATION,  60'd0);
        // focal 1.0, cx 128, cy 128 in Q12.4
        cfg_write(REG_INTRINSICS,   {12'd0, 16'd2048, 16'd2048, 16'd16});
        cfg_write(REG_IMAGE_SIZE,   60'(isz));
        cfg_write(REG_MAX_ERROR,    60'(err));
    endtask

    task automatic random_burst(int count);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 2) != 0)
                    pause_sender();
            end
            send_item(random_item());
            burst--;
        end
    endtask

    // Stimulus
    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes and every status but bypass under the default camera
        camera_setup(1'b1, 16'd655, 18'd131328);
        send_item(depth_write(8'd0, 8'd0, 20'hFFFFF));
        send_item(depth_write(8'd255, 8'd255, 20'd256));
        send_item(depth_write(8'd128, 8'd128, 20'd256));
        send_item(depth_write(8'd10, 8'd20, 20'd0));
        send_item(test_point(20'sd0, 20'sd0, 20'sd256));
        send_item(test_point(20'sd0, 20'sd0, 20'sd300));
        send_item(test_point(20'sd0, 20'sd0, -20'sd5));
        send_item(test_point(20'sd0, 20'sd0, 20'sd0));
        send_item(test_point(20'sd32512, 20'sd32512, 20'sd256));
        send_item(test_point(20'sd32768, 20'sd0, 20'sd256));
        send_item(test_point(-20'sd32768, -20'sd32768, 20'sd256));
        send_item(test_point(-20'sd32769, 20'sd0, 20'sd256));
        send_item(test_point(20'sd5120, 20'sd2560, -20'sd524288));
        send_item(test_point(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF));
        send_item(test_point(20'sh80000, 20'sh80000, 20'sh7FFFF));
        send_item(test_point(20'sd100, -20'sd100, 20'sd1));
        drain_results();

        // Bypass with extreme rotation/translation
        cfg_write(REG_CHECK_ENABLE, 60'd0);
        cfg_write(REG_ROT_ROW_TWO, 60'hFFFF_8000_7FFF);
        cfg_write(REG_TRANSLATION, 60'hFFFFF_80000_7FFFF);
        send_item(test_point(20'sh7FFFF, 20'sh80000, 20'sh7FFFF));
        send_item(test_point(20'sh80000, 20'sh7FFFF, 20'sh80000));
        drain_results();

        // Zero error bound and tiny image, then wide image, then zero image height
        camera_setup(1'b1, 16'd0, {9'd1, 9'd1});
        random_burst(150);
        drain_results();
        camera_setup(1'b1, 16'hFFFF, {9'd511, 9'd511});
        random_burst(250);
        drain_results();
        camera_setup(1'b1, 16'd655, {9'd0, 9'd200});
        random_burst(30);
        drain_results();

        // Long receiver hold-off while the sender keeps going
        camera_setup(1'b1, 16'd2000, 18'd131328);
        fork
            begin
                hold_off = 1'b1;
                repeat (400)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            random_burst(300);
        join
        drain_results();

        // Random rotations, translation and intrinsics
        cfg_write(REG_ROT_ROW_ZERO, 60'({$urandom, $urandom}));
        cfg_write(REG_ROT_ROW_ONE,  60'({$urandom, $urandom}));
        cfg_write(REG_ROT_ROW_TWO,  60'({$urandom, $urandom}));
        cfg_write(REG_TRANSLATION,  60'({$urandom, $urandom}));
        cfg_write(REG_INTRINSICS,   60'({$urandom, $urandom}));
        random_burst(150);
        drain_results();

        // Back to the aimed camera, bypass on and then off
        camera_setup(1'b0, 16'd655, 18'd131328);
        random_burst(80);
        drain_results();
        camera_setup(1'b1, 16'd100, 18'd131328);
        random_burst(250);
        drain_results();

        if (fail_count == 0)
            $display("PASS point_depth_visibility_test");
        else
            $display("FAIL point_depth_visibility_test");
        $finish;
    end

    // Watchdog: store clear plus the whole run with wide margin
    initial
    begin
        #60000000;
        $display("FAIL point_depth_visibility_test");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pdvt_pkg.sv
hw/rtl/point_depth_visibility_test.sv
test/pdvt_checker.sv
test/tb_point_depth_visibility_test.sv
